### sv/i2crb_pkg.sv
// Shared types and constants for the i2c target register bank.
// Used by i2crb_ctrl, i2crb_dpath and i2c_target_register_bank; no dependencies.
package i2crb_pkg;

    // register storage geometry
    localparam int MEM_DEPTH = 256;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [8:0] MEM_DEPTH_W = 9'(MEM_DEPTH);

    // reset value of the writable boundary
    localparam logic [8:0] BOUNDARY_RESET = 9'h080;

    // event codes carried on s_tuser
    typedef enum logic [2:0] {
        REQ_BUS_BYTE    = 3'd0,
        REQ_BUS_READ    = 3'd1,
        REQ_BUS_STOP    = 3'd2,
        REQ_LOCAL_WRITE = 3'd3,
        REQ_LOCAL_READ  = 3'd4
    } req_kind_t;

    // controller states
    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;  // latch the item and read storage
        logic execute;  // update state and load the result register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free; // result register empty or being drained this cycle
    } dp_sts_t;

endpackage

### sv/i2crb_ctrl.sv
// Controller state machine of the i2c target register bank.
// Depends on i2crb_pkg for the state type and the command/status structs.
module i2crb_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  i2crb_pkg::dp_sts_t sts,
    output i2crb_pkg::dp_cmd_t cmd
);

    i2crb_pkg::ctrl_state_t state_reg;
    i2crb_pkg::ctrl_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= i2crb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            i2crb_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = i2crb_pkg::ST_EXEC;
                end
            end
            i2crb_pkg::ST_EXEC: begin
                if (sts.out_free) begin
                    cmd.execute = 1'b1;
                    state_next  = i2crb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = i2crb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### sv/i2crb_dpath.sv
// Datapath of the i2c target register bank: storage, pointer, boundary, result register.
// Depends on i2crb_pkg for constants, event codes and the command/status structs.
module i2crb_dpath (
    input  logic               aclk,
    input  logic               aresetn,
    input  i2crb_pkg::dp_cmd_t cmd,
    output i2crb_pkg::dp_sts_t sts,
    input  logic [2:0]         in_kind,
    input  logic [7:0]         in_data,
    input  logic [7:0]         in_laddr,
    input  logic               cfg_valid,
    input  logic [8:0]         cfg_data,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         out_read_data,
    output logic               out_byte_stored,
    output logic               out_pointer_loaded
);

    logic [7:0]  mem [i2crb_pkg::MEM_DEPTH];
    logic [i2crb_pkg::MEM_DEPTH-1:0] entry_valid_reg;

    logic [8:0]  boundary_reg;
    logic [7:0]  ptr_reg;
    logic        ptr_valid_reg;

    logic [2:0]  kind_reg;
    logic [7:0]  data_reg;
    logic [7:0]  laddr_reg;
    logic [7:0]  rd_raw_reg;
    logic        rd_ok_reg;

    logic        out_valid_reg;
    logic [7:0]  out_rd_reg;
    logic        out_stored_reg;
    logic        out_loaded_reg;

    logic [7:0]  rd_addr;
    logic        rd_in_range;
    logic [7:0]  rd_val;
    logic        we;
    logic [7:0]  waddr;
    logic [7:0]  rd_next;
    logic        stored_next;
    logic        loaded_next;
    logic [7:0]  ptr_next;
    logic        ptr_valid_next;

    assign sts.out_free = !out_valid_reg || m_tready;

    // read address: local events use their own address, bus reads use the pointer
    always_comb begin
        if (in_kind == i2crb_pkg::REQ_LOCAL_WRITE || in_kind == i2crb_pkg::REQ_LOCAL_READ) begin
            rd_addr = in_laddr;
        end else begin
            rd_addr = ptr_reg;
        end
        rd_in_range = ({1'b0, rd_addr} < i2crb_pkg::MEM_DEPTH_W);
    end

    // item capture and registered storage read
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg   <= in_kind;
            data_reg   <= in_data;
            laddr_reg  <= in_laddr;
            rd_raw_reg <= mem[rd_addr[i2crb_pkg::MEM_AW-1:0]];
            rd_ok_reg  <= rd_in_range && entry_valid_reg[rd_addr[i2crb_pkg::MEM_AW-1:0]];
        end
    end

    assign rd_val = rd_ok_reg ? rd_raw_reg : 8'd0;

    // event decode
    always_comb begin
        we             = 1'b0;
        waddr          = laddr_reg;
        rd_next        = 8'd0;
        stored_next    = 1'b0;
        loaded_next    = 1'b0;
        ptr_next       = ptr_reg;
        ptr_valid_next = ptr_valid_reg;
        case (kind_reg)
            i2crb_pkg::REQ_BUS_BYTE: begin
                if (!ptr_valid_reg) begin
                    ptr_next       = data_reg;
                    ptr_valid_next = 1'b1;
                    loaded_next    = 1'b1;
                end else if ({1'b0, ptr_reg} >= boundary_reg &&
                             {1'b0, ptr_reg} < i2crb_pkg::MEM_DEPTH_W) begin
                    we          = 1'b1;
                    waddr       = ptr_reg;
                    stored_next = 1'b1;
                end
            end
            i2crb_pkg::REQ_BUS_READ: begin
                rd_next  = rd_val;
                ptr_next = ptr_reg + 8'd1;
            end
            i2crb_pkg::REQ_BUS_STOP: begin
                ptr_valid_next = 1'b0;
            end
            i2crb_pkg::REQ_LOCAL_WRITE: begin
                if ({1'b0, laddr_reg} < i2crb_pkg::MEM_DEPTH_W) begin
                    we          = 1'b1;
                    stored_next = 1'b1;
                end
            end
            i2crb_pkg::REQ_LOCAL_READ: begin
                rd_next = rd_val;
            end
            default: begin
            end
        endcase
    end

    // storage write
    always_ff @(posedge aclk) begin
        if (cmd.execute && we) begin
            mem[waddr[i2crb_pkg::MEM_AW-1:0]] <= data_reg;
        end
    end

    // per-entry valid bits, cleared at reset so unwritten entries read zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
        end else if (cmd.execute && we) begin
            entry_valid_reg[waddr[i2crb_pkg::MEM_AW-1:0]] <= 1'b1;
        end
    end

    // pointer, pointer flag and boundary
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg       <= 8'd0;
            ptr_valid_reg <= 1'b0;
            boundary_reg  <= i2crb_pkg::BOUNDARY_RESET;
        end else begin
            if (cmd.execute) begin
                ptr_reg       <= ptr_next;
                ptr_valid_reg <= ptr_valid_next;
            end
            if (cfg_valid) begin
                boundary_reg <= cfg_data;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.execute) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            out_rd_reg     <= rd_next;
            out_stored_reg <= stored_next;
            out_loaded_reg <= loaded_next;
        end
    end

    assign m_tvalid           = out_valid_reg;
    assign out_read_data      = out_rd_reg;
    assign out_byte_stored    = out_stored_reg;
    assign out_pointer_loaded = out_loaded_reg;

endmodule

### sv/i2c_target_register_bank.sv
// Register bank behind an I2C target with a local device-side port. Each input
// transfer is one event (bus byte, bus read request, bus stop/restart, local
// write, local read) and yields exactly one result transfer. ST_IDLE captures
// an event and reads the register storage (registered read port); ST_EXEC,
// when the result register is free, writes storage, updates the pointer and
// loads the result; the next event is accepted while it waits on m_tready.
// The first bus byte after reset or a stop/restart loads the pointer; later
// bus bytes are written at the pointer only when it is at or above the
// writable boundary. Registers read as zero until first written.
// Depends on i2crb_pkg, i2crb_ctrl and i2crb_dpath.
module i2c_target_register_bank (
    input  logic        aclk,
    input  logic        aresetn,
    // input events
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [15:8] local_address
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] read_data, [8] byte_stored,
                                   // [9] pointer_loaded, [15:10] zero
    // writable boundary register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data
);

    i2crb_pkg::dp_cmd_t cmd;
    i2crb_pkg::dp_sts_t sts;
    logic [7:0] read_data;
    logic       byte_stored;
    logic       pointer_loaded;

    assign cfg_ready = 1'b1;

    i2crb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    i2crb_dpath u_dpath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .in_kind            (s_tuser),
        .in_data            (s_tdata[7:0]),
        .in_laddr           (s_tdata[15:8]),
        .cfg_valid          (cfg_valid),
        .cfg_data           (cfg_data),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .out_read_data      (read_data),
        .out_byte_stored    (byte_stored),
        .out_pointer_loaded (pointer_loaded)
    );

    // pack result fields
    assign m_tdata = {6'd0, pointer_loaded, byte_stored, read_data};

endmodule
